### rtl/env_sensor_compensation_macros.svh
// assertion helpers
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ESC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/esc_pkg.sv
package esc_pkg;

   localparam int FRONT_STAGES = 13;
   localparam int DIV_STAGES   = 32;
   localparam int POST_STAGES  = 3;

   localparam logic [2:0] REG_TEMP_CAL   = 3'd0;
   localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
   localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
   localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
   localparam logic [2:0] REG_HUMID_CAL  = 3'd4;
   localparam logic [2:0] REG_HAS_HUMID  = 3'd5;

   localparam logic [31:0] HUM_MAX = 32'd419430400;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] qd;
      logic [31:0] divisor;
      logic [31:0] temp;
      logic [16:0] hum;
      logic        zero;
      logic        by2;
   } div_type;

   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic        hum_en;
   } cal_type;

   typedef struct packed {
      logic [19:0] rp;
      logic [19:0] rt;
      logic [15:0] rh;
      logic [31:0] m1, dd, m2, v1t, tf, temp, pv1, q, hx;
      logic [31:0] sq, m5, mp2, ha, hb, hc;
      logic [31:0] v2a, mp3, left, hr1;
      logic [31:0] v2, pv1b, hr2;
      logic [31:0] pv1c, pn, right;
      logic [31:0] pv1d, pnum, hx2;
      logic [31:0] hy, dividend;
      logic        zero, by2;
      logic [31:0] ysq, hz;
      logic [16:0] hum;
   } front_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [16:0] hum;
      logic        zero;
      logic [31:0] p, sqp, bm, am, bb, pout;
   } post_type;

   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
      return 32'($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] full;
      full = a * b;
      return full[31:0];
   endfunction

endpackage

### rtl/esc_divider.sv
module esc_divider import esc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   div_type               st_ff [DIV_STAGES];
   div_type               st_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] v_ff;
   logic [DIV_STAGES-1:0] en;

   // one quotient bit per stage, restoring
   function automatic div_type div_step(input div_type s);
      div_type     o;
      logic [32:0] t;
      o = s;
      t = {s.rem, s.qd[31]};
      if (t >= {1'b0, s.divisor}) begin
         t = t - {1'b0, s.divisor};
         o.qd = {s.qd[30:0], 1'b1};
      end else begin
         o.qd = {s.qd[30:0], 1'b0};
      end
      o.rem = t[31:0];
      return o;
   endfunction

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      if (g == DIV_STAGES - 1) begin : g_last
         assign en[g] = !v_ff[g] || out_ready;
      end else begin : g_mid
         assign en[g] = !v_ff[g] || en[g+1];
      end
      if (g == 0) begin : g_first
         assign st_in[g] = div_step(in_data);
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (en[g]) begin
               v_ff[g] <= in_valid;
            end
         end
      end else begin : g_next
         assign st_in[g] = div_step(st_ff[g-1]);
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (en[g]) begin
               v_ff[g] <= v_ff[g-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en[g]) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data  = st_ff[DIV_STAGES-1];

endmodule

### rtl/env_sensor_compensation.sv
// Compensates one set of raw pressure, temperature and humidity readings per
// clock while rsp is not stalled, with the usual 32-bit integer calibration
// formulas, all math wrapping at 32 bits. Calibration words must be written
// through the csr port only while no transfer is in flight; the block itself
// does not enforce this. A req passes 13 front stages, a 32-stage pressure
// divider (one bit per stage) and 3 final stages. Every stage holds its item
// under back-pressure and fills bubbles, so rsp stalls never drop data.
// A zero pressure divisor gives pressure 0 with the divisor-zero flag set.
module env_sensor_compensation import esc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_raw_pressure,
   input  logic [19:0]        req_raw_temperature,
   input  logic [15:0]        req_raw_humidity,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0]        rsp_pressure_pa,
   output logic [16:0]        rsp_humidity_q10,
   output logic               rsp_pressure_divisor_zero,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

`include "env_sensor_compensation_macros.svh"

   logic [47:0] temp_cal_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_c_ff;
   logic [63:0] humid_cal_ff;
   logic        has_hum_ff;
   cal_type     cal;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff  <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
         humid_cal_ff <= '0;
         has_hum_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_TEMP_CAL:    temp_cal_ff  <= csr_wdata[47:0];
            REG_PRESS_CAL_A: press_a_ff   <= csr_wdata;
            REG_PRESS_CAL_B: press_b_ff   <= csr_wdata;
            REG_PRESS_CAL_C: press_c_ff   <= csr_wdata[15:0];
            REG_HUMID_CAL:   humid_cal_ff <= csr_wdata;
            REG_HAS_HUMID:   has_hum_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = {16'd0, temp_cal_ff[15:0]};
      cal.t2 = {{16{temp_cal_ff[31]}}, temp_cal_ff[31:16]};
      cal.t3 = {{16{temp_cal_ff[47]}}, temp_cal_ff[47:32]};
      cal.p1 = {16'd0, press_a_ff[15:0]};
      cal.p2 = {{16{press_a_ff[31]}}, press_a_ff[31:16]};
      cal.p3 = {{16{press_a_ff[47]}}, press_a_ff[47:32]};
      cal.p4 = {{16{press_a_ff[63]}}, press_a_ff[63:48]};
      cal.p5 = {{16{press_b_ff[15]}}, press_b_ff[15:0]};
      cal.p6 = {{16{press_b_ff[31]}}, press_b_ff[31:16]};
      cal.p7 = {{16{press_b_ff[47]}}, press_b_ff[47:32]};
      cal.p8 = {{16{press_b_ff[63]}}, press_b_ff[63:48]};
      cal.p9 = {{16{press_c_ff[15]}}, press_c_ff};
      cal.h1 = {24'd0, humid_cal_ff[7:0]};
      cal.h2 = {{16{humid_cal_ff[23]}}, humid_cal_ff[23:8]};
      cal.h3 = {24'd0, humid_cal_ff[31:24]};
      cal.h4 = {{20{humid_cal_ff[39]}}, humid_cal_ff[39:32], humid_cal_ff[43:40]};
      cal.h5 = {{20{humid_cal_ff[55]}}, humid_cal_ff[55:48], humid_cal_ff[47:44]};
      cal.h6 = {{24{humid_cal_ff[63]}}, humid_cal_ff[63:56]};
      cal.hum_en = has_hum_ff;
   end

   function automatic front_type front_step(input int k, input front_type s,
                                            input cal_type c);
      front_type   o;
      logic [31:0] x;
      o = s;
      x = '0;
      case (k)
         0: begin
            o.m1 = mul(({12'd0, s.rt} >> 3) - (c.t1 << 1), c.t2);
            x    = ({12'd0, s.rt} >> 4) - c.t1;
            o.dd = mul(x, x);
         end
         1: begin
            o.v1t = asr(s.m1, 5'd11);
            o.m2  = mul(asr(s.dd, 5'd12), c.t3);
         end
         2: o.tf = s.v1t + asr(s.m2, 5'd14);
         3: begin
            o.temp = asr(s.tf + (s.tf << 2) + 32'd128, 5'd8);
            x      = asr(s.tf, 5'd1) - 32'd64000;
            o.pv1  = x;
            o.q    = asr(x, 5'd2);
            o.hx   = s.tf - 32'd76800;
         end
         4: begin
            o.sq  = mul(s.q, s.q);
            o.m5  = mul(s.pv1, c.p5);
            o.mp2 = mul(c.p2, s.pv1);
            o.ha  = mul(c.h5, s.hx);
            o.hb  = mul(s.hx, c.h6);
            o.hc  = mul(s.hx, c.h3);
         end
         5: begin
            o.v2a  = mul(asr(s.sq, 5'd11), c.p6);
            o.mp3  = mul(c.p3, asr(s.sq, 5'd13));
            o.left = asr(({16'd0, s.rh} << 14) - (c.h4 << 20) - s.ha + 32'd16384,
                         5'd15);
            o.hr1  = mul(asr(s.hb, 5'd10), asr(s.hc, 5'd11) + 32'd32768);
         end
         6: begin
            o.v2   = asr(s.v2a + (s.m5 << 1), 5'd2) + (c.p4 << 16);
            o.pv1b = asr(asr(s.mp3, 5'd3) + asr(s.mp2, 5'd1), 5'd18);
            o.hr2  = mul(asr(s.hr1, 5'd10) + 32'd2097152, c.h2);
         end
         7: begin
            o.pv1c  = mul(32'd32768 + s.pv1b, c.p1);
            o.pn    = (32'd1048576 - {12'd0, s.rp}) - asr(s.v2, 5'd12);
            o.right = asr(s.hr2 + 32'd8192, 5'd14);
         end
         8: begin
            o.pv1d = asr(s.pv1c, 5'd15);
            o.pnum = mul(s.pn, 32'd3125);
            o.hx2  = mul(s.left, s.right);
         end
         9: begin
            o.hy       = asr(s.hx2, 5'd15);
            o.zero     = (s.pv1d == '0);
            o.by2      = s.pnum[31];
            o.dividend = s.pnum[31] ? s.pnum : (s.pnum << 1);
         end
         10: o.ysq = mul(s.hy, s.hy);
         11: o.hz = mul(asr(s.ysq, 5'd7), c.h1);
         12: begin
            x = s.hx2 - asr(s.hz, 5'd4);
            if (x[31]) begin
               x = '0;
            end else if (x > HUM_MAX) begin
               x = HUM_MAX;
            end
            o.hum = c.hum_en ? x[28:12] : '0;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic post_type post_step(input int k, input post_type s,
                                          input cal_type c);
      post_type o;
      o = s;
      case (k)
         0: begin
            o.sqp = mul(s.p >> 3, s.p >> 3);
            o.bm  = mul(s.p >> 2, c.p8);
         end
         1: begin
            o.am = mul(c.p9, s.sqp >> 13);
            o.bb = asr(s.bm, 5'd13);
         end
         2: o.pout = s.zero ? '0 : s.p + asr(asr(s.am, 5'd12) + s.bb + c.p7, 5'd4);
         default: ;
      endcase
      return o;
   endfunction

   // front section: temperature, pressure terms, humidity
   front_type               fr_ff [FRONT_STAGES];
   front_type               fr_in [FRONT_STAGES];
   logic [FRONT_STAGES-1:0] fv_ff;
   logic [FRONT_STAGES-1:0] fen;
   front_type               req_item;
   logic                    div_in_ready;
   div_type                 div_in;
   logic                    div_out_valid;
   logic                    post_ready;
   div_type                 div_out;

   always_comb begin
      req_item    = '0;
      req_item.rp = req_raw_pressure;
      req_item.rt = req_raw_temperature;
      req_item.rh = req_raw_humidity;
   end

   for (genvar g = 0; g < FRONT_STAGES; g++) begin : g_front
      if (g == FRONT_STAGES - 1) begin : g_last
         assign fen[g] = !fv_ff[g] || div_in_ready;
      end else begin : g_mid
         assign fen[g] = !fv_ff[g] || fen[g+1];
      end
      if (g == 0) begin : g_first
         assign fr_in[g] = front_step(g, req_item, cal);
         always_ff @(posedge clock) begin
            if (reset) begin
               fv_ff[g] <= 1'b0;
            end else if (fen[g]) begin
               fv_ff[g] <= req_valid;
            end
         end
      end else begin : g_next
         assign fr_in[g] = front_step(g, fr_ff[g-1], cal);
         always_ff @(posedge clock) begin
            if (reset) begin
               fv_ff[g] <= 1'b0;
            end else if (fen[g]) begin
               fv_ff[g] <= fv_ff[g-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (fen[g]) begin
            fr_ff[g] <= fr_in[g];
         end
      end
   end

   assign req_ready = fen[0];

   always_comb begin
      div_in.rem     = '0;
      div_in.qd      = fr_ff[FRONT_STAGES-1].dividend;
      div_in.divisor = fr_ff[FRONT_STAGES-1].pv1d;
      div_in.temp    = fr_ff[FRONT_STAGES-1].temp;
      div_in.hum     = fr_ff[FRONT_STAGES-1].hum;
      div_in.zero    = fr_ff[FRONT_STAGES-1].zero;
      div_in.by2     = fr_ff[FRONT_STAGES-1].by2;
   end

   esc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fv_ff[FRONT_STAGES-1]),
      .in_ready  (div_in_ready),
      .in_data   (div_in),
      .out_valid (div_out_valid),
      .out_ready (post_ready),
      .out_data  (div_out)
   );

   // final pressure correction
   post_type               po_ff [POST_STAGES];
   post_type               po_in [POST_STAGES];
   logic [POST_STAGES-1:0] pv_ff;
   logic [POST_STAGES-1:0] pen;
   post_type               div_item;

   always_comb begin
      div_item      = '0;
      div_item.temp = div_out.temp;
      div_item.hum  = div_out.hum;
      div_item.zero = div_out.zero;
      div_item.p    = div_out.by2 ? (div_out.qd << 1) : div_out.qd;
   end

   for (genvar g = 0; g < POST_STAGES; g++) begin : g_post
      if (g == POST_STAGES - 1) begin : g_last
         assign pen[g] = !pv_ff[g] || rsp_ready;
      end else begin : g_mid
         assign pen[g] = !pv_ff[g] || pen[g+1];
      end
      if (g == 0) begin : g_first
         assign po_in[g] = post_step(g, div_item, cal);
         always_ff @(posedge clock) begin
            if (reset) begin
               pv_ff[g] <= 1'b0;
            end else if (pen[g]) begin
               pv_ff[g] <= div_out_valid;
            end
         end
      end else begin : g_next
         assign po_in[g] = post_step(g, po_ff[g-1], cal);
         always_ff @(posedge clock) begin
            if (reset) begin
               pv_ff[g] <= 1'b0;
            end else if (pen[g]) begin
               pv_ff[g] <= pv_ff[g-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (pen[g]) begin
            po_ff[g] <= po_in[g];
         end
      end
   end

   assign post_ready                = pen[0];
   assign rsp_valid                 = pv_ff[POST_STAGES-1];
   assign rsp_temperature_centi     = po_ff[POST_STAGES-1].temp;
   assign rsp_pressure_pa           = po_ff[POST_STAGES-1].pout;
   assign rsp_humidity_q10          = po_ff[POST_STAGES-1].hum;
   assign rsp_pressure_divisor_zero = po_ff[POST_STAGES-1].zero;

   `ESC_ASSERT_IMPL(a_hum_range, clock, reset, rsp_valid, rsp_humidity_q10 <= 17'd102400)
   `ESC_ASSERT_IMPL(a_zero_press, clock, reset, rsp_valid && rsp_pressure_divisor_zero, rsp_pressure_pa == '0)
   `ESC_ASSERT_IMPL(a_no_hum, clock, reset, rsp_valid && !has_hum_ff, rsp_humidity_q10 == '0)
   `ESC_ASSERT_NEXT(a_div_hold, clock, reset, div_out_valid && !post_ready, div_out_valid)

endmodule

### sim/env_sensor_compensation_checker.sv
module env_sensor_compensation_checker import esc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [19:0]        req_raw_pressure,
   input  logic [19:0]        req_raw_temperature,
   input  logic [15:0]        req_raw_humidity,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_temperature_centi,
   input  logic [31:0]        rsp_pressure_pa,
   input  logic [16:0]        rsp_humidity_q10,
   input  logic               rsp_pressure_divisor_zero,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending_count,
   output int                 checked_count,
   output int                 zero_div_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] hum;
      logic        zero;
   } reading_type;

   logic [47:0] cal_t;
   logic [63:0] cal_pa, cal_pb, cal_h;
   logic [15:0] cal_pc;
   logic        hum_on;
   reading_type expected_readings[$];

   function automatic logic [31:0] sra(logic [31:0] v, int n);
      return 32'($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
      logic [63:0] f;
      f = {32'd0, a} * {32'd0, b};
      return f[31:0];
   endfunction

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx8(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   function automatic reading_type compensate(logic [19:0] rp0, logic [19:0] rt0,
                                              logic [15:0] rh0);
      reading_type r;
      logic [31:0] rp, rt, rh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] v1, v2, d, tf, sq, q, p, a, b, x, y, lft, rgt;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      rp = {12'd0, rp0};
      rt = {12'd0, rt0};
      rh = {16'd0, rh0};
      t1 = {16'd0, cal_t[15:0]};
      t2 = sx16(cal_t[31:16]);
      t3 = sx16(cal_t[47:32]);
      p1 = {16'd0, cal_pa[15:0]};
      p2 = sx16(cal_pa[31:16]);
      p3 = sx16(cal_pa[47:32]);
      p4 = sx16(cal_pa[63:48]);
      p5 = sx16(cal_pb[15:0]);
      p6 = sx16(cal_pb[31:16]);
      p7 = sx16(cal_pb[47:32]);
      p8 = sx16(cal_pb[63:48]);
      p9 = sx16(cal_pc);
      v1 = sra(mul32((rt >> 3) - (t1 << 1), t2), 11);
      d = (rt >> 4) - t1;
      v2 = sra(mul32(sra(mul32(d, d), 12), t3), 14);
      tf = v1 + v2;
      r.temp = sra(mul32(tf, 32'd5) + 32'd128, 8);
      v1 = sra(tf, 1) - 32'd64000;
      q = sra(v1, 2);
      sq = mul32(q, q);
      v2 = mul32(sra(sq, 11), p6);
      v2 = v2 + (mul32(v1, p5) << 1);
      v2 = sra(v2, 2) + (p4 << 16);
      v1 = sra(sra(mul32(p3, sra(sq, 13)), 3) + sra(mul32(p2, v1), 1), 18);
      v1 = sra(mul32(32'd32768 + v1, p1), 15);
      r.zero = (v1 == '0);
      if (r.zero) begin
         p = '0;
      end else begin
         p = mul32((32'd1048576 - rp) - sra(v2, 12), 32'd3125);
         if (p < 32'h8000_0000) p = (p << 1) / v1;
         else p = (p / v1) * 32'd2;
         a = sra(mul32(p9, mul32(p >> 3, p >> 3) >> 13), 12);
         b = sra(mul32(p >> 2, p8), 13);
         p = p + sra(a + b + p7, 4);
      end
      r.press = p;
      r.hum = '0;
      if (hum_on) begin
         h1 = {24'd0, cal_h[7:0]};
         h2 = sx16(cal_h[23:8]);
         h3 = {24'd0, cal_h[31:24]};
         h4 = (sx8(cal_h[39:32]) << 4) | {28'd0, cal_h[43:40]};
         h5 = (sx8(cal_h[55:48]) << 4) | {28'd0, cal_h[47:44]};
         h6 = sx8(cal_h[63:56]);
         x = tf - 32'd76800;
         lft = sra((rh << 14) - (h4 << 20) - mul32(h5, x) + 32'd16384, 15);
         rgt = sra(mul32(sra(mul32(sra(mul32(x, h6), 10),
                                   sra(mul32(x, h3), 11) + 32'd32768), 10)
                         + 32'd2097152, h2) + 32'd8192, 14);
         x = mul32(lft, rgt);
         y = sra(x, 15);
         x = x - sra(mul32(sra(mul32(y, y), 7), h1), 4);
         if (x[31]) x = '0;
         else if (x > HUM_MAX) x = HUM_MAX;
         r.hum = x[28:12];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reading_type w;
      if (reset) begin
         cal_t <= '0; cal_pa <= '0; cal_pb <= '0; cal_pc <= '0; cal_h <= '0;
         hum_on <= 1'b1;
         fail_count <= 0;
         checked_count <= 0;
         zero_div_count <= 0;
         expected_readings.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_TEMP_CAL: cal_t <= csr_wdata[47:0];
               REG_PRESS_CAL_A: cal_pa <= csr_wdata;
               REG_PRESS_CAL_B: cal_pb <= csr_wdata;
               REG_PRESS_CAL_C: cal_pc <= csr_wdata[15:0];
               REG_HUMID_CAL: cal_h <= csr_wdata;
               REG_HAS_HUMID: hum_on <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_pressure_pa, 32'd0);
            end else begin
               w = expected_readings.pop_front();
               checked_count <= checked_count + 1;
               if (w.zero) zero_div_count <= zero_div_count + 1;
               if (rsp_temperature_centi !== w.temp)
                  report_mismatch("temperature", rsp_temperature_centi, w.temp);
               if (rsp_pressure_pa !== w.press)
                  report_mismatch("pressure", rsp_pressure_pa, w.press);
               if (rsp_humidity_q10 !== w.hum)
                  report_mismatch("humidity", {15'd0, rsp_humidity_q10}, {15'd0, w.hum});
               if (rsp_pressure_divisor_zero !== w.zero)
                  report_mismatch("divisor zero", {31'd0, rsp_pressure_divisor_zero},
                                  {31'd0, w.zero});
            end
         end
         if (req_valid && req_ready)
            expected_readings.push_back(compensate(req_raw_pressure,
                                                   req_raw_temperature,
                                                   req_raw_humidity));
      end
      pending_count = expected_readings.size();
   end
endmodule

### sim/env_sensor_compensation_test.sv
module env_sensor_compensation_test import esc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = FRONT_STAGES + DIV_STAGES + POST_STAGES;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [19:0]        req_raw_pressure = '0;
   logic [19:0]        req_raw_temperature = '0;
   logic [15:0]        req_raw_humidity = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0]        rsp_pressure_pa;
   logic [16:0]        rsp_humidity_q10;
   logic               rsp_pressure_divisor_zero;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;
   int                 fail_count, pending_count, checked_count, zero_div_count;
   int                 cycle_count = 0;
   int                 send_idle = 0;
   int                 recv_stall = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   env_sensor_compensation u_top (.*);

   env_sensor_compensation_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("env_sensor_compensation_test NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic typical_calibration();
      write_reg(REG_TEMP_CAL, 64'({16'(-$urandom_range(1000)),
                                   16'($urandom_range(20000, 30000)),
                                   16'($urandom_range(25000, 32000))}));
      write_reg(REG_PRESS_CAL_A, {16'($urandom_range(5000, 9000)),
                                  16'($urandom_range(3000, 5000)),
                                  16'(-$urandom_range(9000, 12000)),
                                  16'($urandom_range(30000, 40000))});
      write_reg(REG_PRESS_CAL_B, {16'(-$urandom_range(8000, 16000)),
                                  16'($urandom_range(0, 20000)),
                                  16'(-$urandom_range(0, 100)),
                                  16'($urandom_range(0, 300))});
      write_reg(REG_PRESS_CAL_C, 64'($urandom_range(3000, 6000)));
      write_reg(REG_HUMID_CAL, {8'($urandom_range(20, 40)), 8'($urandom),
                                8'($urandom), 8'($urandom),
                                8'($urandom_range(0, 60)),
                                16'($urandom_range(300, 400)), 8'($urandom)});
   endtask

   task automatic send_reading(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_pressure <= rp;
      req_raw_temperature <= rt;
      req_raw_humidity <= rh;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      int i, phase, sent;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_reading(20'd0, 20'd0, 16'd0);
      send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      drain();
      typical_calibration();
      send_reading(20'd415148, 20'd519888, 16'd30000);
      send_reading(20'd0, 20'hFFFFF, 16'd0);
      send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
      send_reading(20'h55555, 20'hAAAAA, 16'h5555);
      send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
      drain();
      write_reg(REG_HAS_HUMID, 64'd0);
      send_reading(20'd400000, 20'd520000, 16'hFFFF);
      send_reading(20'd300000, 20'd500000, 16'd0);
      drain();
      write_reg(REG_HAS_HUMID, 64'd1);
      write_reg(REG_PRESS_CAL_A, 64'hFFFF_FFFF_FFFF_0000);
      send_reading(20'd400000, 20'd520000, 16'd20000);
      drain();
      write_reg(REG_TEMP_CAL, 64'h0000_7FFF_8000_FFFF);
      write_reg(REG_PRESS_CAL_A, 64'h7FFF_8000_7FFF_FFFF);
      write_reg(REG_PRESS_CAL_B, 64'h8000_7FFF_8000_7FFF);
      write_reg(REG_PRESS_CAL_C, 64'h8000);
      write_reg(REG_HUMID_CAL, 64'h7F00_FF80_FF80_00FF);
      send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_reading(20'd0, 20'd0, 16'd0);
      send_reading(20'd12345, 20'd678901, 16'd4321);
      drain();
      write_reg(REG_HUMID_CAL, 64'h80FF_7F7F_00FF_7FFF);
      write_reg(REG_UNUSED, rand64());
      send_reading(20'd1, 20'd1, 16'd1);
      send_reading(20'd500000, 20'd400000, 16'd50000);
      drain();
      sent = 0;
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 72; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 72; end
            default: begin send_idle = 28; recv_stall = 28; end
         endcase
         if (phase == 5) begin
            write_reg(REG_TEMP_CAL, rand64());
            write_reg(REG_PRESS_CAL_A, rand64());
            write_reg(REG_PRESS_CAL_B, rand64());
            write_reg(REG_PRESS_CAL_C, rand64());
            write_reg(REG_HUMID_CAL, rand64());
         end else begin
            typical_calibration();
         end
         write_reg(REG_HAS_HUMID, 64'(phase != 3));
         for (i = 0; i < 80; i++) begin
            if ($urandom_range(9) < 8)
               send_reading(20'($urandom_range(250000, 600000)),
                            20'($urandom_range(350000, 650000)), 16'($urandom));
            else
               send_reading(20'($urandom), 20'($urandom), 16'($urandom));
            sent++;
         end
         drain();
      end
      recv_stall = 0;
      drain();
      $display("covered %0d readings (%0d random, %0d with zero divisor) over directed",
               checked_count, sent, zero_div_count);
      $display("and random calibration sets, with back-pressure and idle phases");
      if (fail_count == 0 && pending_count == 0) begin
         $display("env_sensor_compensation_test OK");
      end else begin
         $display("env_sensor_compensation_test NOT OK");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_divider.sv
rtl/env_sensor_compensation.sv
sim/env_sensor_compensation_checker.sv
sim/env_sensor_compensation_test.sv
